### rtl/assert_macros.svh
// Assertion helpers for the matcher RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// Same-cycle implication.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: label");
// Next-cycle implication.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: label");
`else
`define ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

### rtl/wspm_pkg.sv
package wspm_pkg;

   // pattern capacity and derived widths
   localparam int PATTERN_MAX = 32;
   localparam int LEN_W = $clog2(PATTERN_MAX + 1);
   localparam int IDX_W = (PATTERN_MAX > 1) ? $clog2(PATTERN_MAX) : 1;
   localparam int SYM_W = 8;

   localparam logic [SYM_W-1:0] SYM_STAR = 8'h2A;
   localparam logic [SYM_W-1:0] SYM_ANY  = 8'h2E;

   typedef enum logic [1:0] {
      FUNC_APPEND = 2'd0,
      FUNC_START  = 2'd1,
      FUNC_TEXT   = 2'd2,
      FUNC_END    = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      ST_IDLE  = 2'b01,
      ST_SWEEP = 2'b10
   } state_type;

   // control from the sequencer to the column unit
   typedef struct packed {
      logic             load;      // begin a row pass
      logic             step;      // compute one column this cycle
      logic             build;     // empty-text row instead of text sweep
      logic             first;     // column one
      logic [SYM_W-1:0] text;      // current text byte
      logic             old_row0;  // row entry zero before the pass
      logic             old_j;     // row entry of this column before the pass
   } col_ctrl_type;

endpackage

### rtl/wspm_ifs.sv
// request channel: command plus byte
interface wspm_req_if;
   logic                     valid;
   logic                     ready;
   logic [1:0]               func;
   logic [wspm_pkg::SYM_W-1:0] symbol;

   modport source (output valid, output func, output symbol, input ready);
   modport sink (input valid, input func, input symbol, output ready);
endinterface

// result channel: match report
interface wspm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic overflowed;

   modport source (output valid, output matched, output overflowed, input ready);
   modport sink (input valid, input matched, input overflowed, output ready);
endinterface

### rtl/wildcard_star_pattern_match_top.sv
// Append and end items are accepted while idle; end's result is registered and
// valid the next cycle. Start and text items sweep the pattern one column a cycle
// through the pattern RAM read port; with an empty pattern no sweep is run.
// No new item is accepted during a sweep or while a result waits to be taken.
// Reset (synchronous): length, overflow and result valid cleared, match row back
// to only entry zero set; pattern RAM contents and result bits are not cleared.
`include "assert_macros.svh"

module wildcard_star_pattern_match_top (
   input  logic       clock,
   input  logic       reset,
   wspm_req_if.sink   req_in,
   wspm_rsp_if.source rsp_out
);

   localparam int MAX = wspm_pkg::PATTERN_MAX;
   localparam int LW  = wspm_pkg::LEN_W;
   localparam int IW  = wspm_pkg::IDX_W;

   wspm_pkg::state_type          state_ff, state_in;
   logic [LW-1:0]                len_ff, len_in;
   logic                         ovf_ff, ovf_in;
   logic [MAX:0]                 row_ff, row_in;
   logic [LW-1:0]                rd_idx_ff, rd_idx_in;
   logic                         rd_pend_ff, rd_pend_in;
   logic [LW-1:0]                col_ff, col_in;
   logic [wspm_pkg::SYM_W-1:0]   sym_ff, sym_in;
   logic                         build_ff, build_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic                         matched_ff, matched_in;
   logic                         overflowed_ff, overflowed_in;

   logic                         accept, issue, wr_en, col_bit;
   logic [wspm_pkg::SYM_W-1:0]   pat_byte;
   wspm_pkg::func_type           func;
   wspm_pkg::col_ctrl_type       ctrl;

   assign func   = wspm_pkg::func_type'(req_in.func);
   assign req_in.ready = (state_ff == wspm_pkg::ST_IDLE) &&
                         (!rsp_valid_ff || rsp_out.ready);
   assign accept = req_in.valid && req_in.ready;
   assign issue  = (state_ff == wspm_pkg::ST_SWEEP) && (rd_idx_ff < len_ff);
   assign wr_en  = accept && (func == wspm_pkg::FUNC_APPEND) &&
                   (len_ff < LW'(MAX));

   // pattern store
   wspm_ram #(.WIDTH(wspm_pkg::SYM_W), .DEPTH(MAX)) u_pat_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (len_ff[IW-1:0]),
      .wr_data (req_in.symbol),
      .rd_en   (issue),
      .rd_addr (rd_idx_ff[IW-1:0]),
      .rd_data (pat_byte)
   );

   // column unit control
   always_comb begin
      ctrl.load     = accept && ((func == wspm_pkg::FUNC_START) ||
                                 (func == wspm_pkg::FUNC_TEXT));
      ctrl.step     = rd_pend_ff;
      ctrl.build    = ctrl.load ? (func == wspm_pkg::FUNC_START) : build_ff;
      ctrl.first    = (col_ff == LW'(1));
      ctrl.text     = sym_ff;
      ctrl.old_row0 = row_ff[0];
      ctrl.old_j    = row_ff[col_ff];
   end

   wspm_col u_col (
      .clock    (clock),
      .ctrl     (ctrl),
      .pat_byte (pat_byte),
      .col_bit  (col_bit)
   );

   // sequencer
   always_comb begin
      state_in      = state_ff;
      len_in        = len_ff;
      ovf_in        = ovf_ff;
      row_in        = row_ff;
      rd_idx_in     = rd_idx_ff;
      rd_pend_in    = issue;
      col_in        = col_ff;
      sym_in        = sym_ff;
      build_in      = build_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_out.ready;
      matched_in    = matched_ff;
      overflowed_in = overflowed_ff;
      if (issue) begin
         rd_idx_in = rd_idx_ff + LW'(1);
      end
      if (rd_pend_ff) begin
         row_in[col_ff] = col_bit;
         col_in         = col_ff + LW'(1);
         if (col_ff == len_ff) begin
            state_in = wspm_pkg::ST_IDLE;
         end
      end
      if (accept) begin
         case (func)
            wspm_pkg::FUNC_APPEND: begin
               if (len_ff < LW'(MAX)) begin
                  len_in = len_ff + LW'(1);
               end else begin
                  ovf_in = 1'b1;
               end
            end
            wspm_pkg::FUNC_START, wspm_pkg::FUNC_TEXT: begin
               row_in[0] = (func == wspm_pkg::FUNC_START);
               build_in  = (func == wspm_pkg::FUNC_START);
               sym_in    = req_in.symbol;
               rd_idx_in = '0;
               col_in    = LW'(1);
               if (len_ff != '0) begin
                  state_in = wspm_pkg::ST_SWEEP;
               end
            end
            wspm_pkg::FUNC_END: begin
               rsp_valid_in  = 1'b1;
               matched_in    = row_ff[len_ff] && !ovf_ff;
               overflowed_in = ovf_ff;
               len_in        = '0;
               ovf_in        = 1'b0;
               row_in        = (MAX + 1)'(1);
            end
            default: begin
               state_in = state_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= wspm_pkg::ST_IDLE;
         len_ff       <= '0;
         ovf_ff       <= 1'b0;
         row_ff       <= (MAX + 1)'(1);
         rd_idx_ff    <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         ovf_ff       <= ovf_in;
         row_ff       <= row_in;
         rd_idx_ff    <= rd_idx_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      col_ff        <= col_in;
      sym_ff        <= sym_in;
      build_ff      <= build_in;
      matched_ff    <= matched_in;
      overflowed_ff <= overflowed_in;
   end

   assign rsp_out.valid      = rsp_valid_ff;
   assign rsp_out.matched    = matched_ff;
   assign rsp_out.overflowed = overflowed_ff;

   // checks
   `ASSERT_IMPLIES(a_busy_not_ready, clock, reset, state_ff == wspm_pkg::ST_SWEEP, !req_in.ready)
   `ASSERT_IMPLIES(a_rd_in_range, clock, reset, state_ff == wspm_pkg::ST_SWEEP, rd_idx_ff <= len_ff)
   `ASSERT_IMPLIES(a_ovf_only_full, clock, reset, ovf_ff, len_ff == LW'(MAX))
   `ASSERT_NEXT(a_end_reports, clock, reset, accept && func == wspm_pkg::FUNC_END, rsp_valid_ff && len_ff == '0)
   `ASSERT_IMPLIES(a_read_in_sweep, clock, reset, rd_pend_ff, state_ff == wspm_pkg::ST_SWEEP)

endmodule

### rtl/wspm_ram.sv
// generic single-write, single-read RAM with registered read data
module wspm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/wspm_col.sv
// One pattern column per step: shared byte compare plus the running
// neighbor bits (new row j-1, j-2, old row j-1, element byte j-2).
module wspm_col (
   input  logic                         clock,
   input  wspm_pkg::col_ctrl_type       ctrl,
   input  logic [wspm_pkg::SYM_W-1:0]   pat_byte,
   output logic                         col_bit
);

   logic                       old_prev_ff, old_prev_in;
   logic                       new_m1_ff, new_m1_in;
   logic                       new_m2_ff, new_m2_in;
   logic [wspm_pkg::SYM_W-1:0] elem_ff, elem_in;
   logic                       is_star, is_any, lit_hit, elem_hit;

   // compares of the pattern and element bytes against the text byte and wildcards
   assign is_star  = (pat_byte == wspm_pkg::SYM_STAR);
   assign is_any   = (pat_byte == wspm_pkg::SYM_ANY);
   assign lit_hit  = (pat_byte == ctrl.text);
   assign elem_hit = (elem_ff == ctrl.text) || (elem_ff == wspm_pkg::SYM_ANY);

   // column value
   always_comb begin
      col_bit = 1'b0;
      if (is_star) begin
         if (ctrl.first) begin
            // leading star: no element, only repeats entry zero
            col_bit = new_m1_ff;
         end else if (ctrl.build) begin
            col_bit = new_m1_ff || new_m2_ff;
         end else begin
            col_bit = new_m1_ff || new_m2_ff || (ctrl.old_j && elem_hit);
         end
      end else if (!ctrl.build) begin
         col_bit = old_prev_ff && (is_any || lit_hit);
      end
   end

   // neighbor tracking
   always_comb begin
      old_prev_in = old_prev_ff;
      new_m1_in   = new_m1_ff;
      new_m2_in   = new_m2_ff;
      elem_in     = elem_ff;
      if (ctrl.load) begin
         old_prev_in = ctrl.old_row0;
         new_m1_in   = ctrl.build;
         new_m2_in   = 1'b0;
      end else if (ctrl.step) begin
         old_prev_in = ctrl.old_j;
         new_m1_in   = col_bit;
         new_m2_in   = new_m1_ff;
         elem_in     = pat_byte;
      end
   end

   always_ff @(posedge clock) begin
      old_prev_ff <= old_prev_in;
      new_m1_ff   <= new_m1_in;
      new_m2_ff   <= new_m2_in;
      elem_ff     <= elem_in;
   end

endmodule

### tb/sv/wildcard_star_pattern_match_top_test.sv
module wildcard_star_pattern_match_top_test;
   timeunit 1ns;
   timeprecision 1ps;

   // cycles with no item moving on either channel before giving up
   localparam int STALL_LIMIT = 5000;
   localparam logic [7:0] CH_A = 8'h61;
   localparam logic [7:0] CH_B = 8'h62;
   localparam logic [7:0] CH_C = 8'h63;
   localparam logic [7:0] CH_X = 8'h78;

   typedef struct {
      logic matched;
      logic overflowed;
   } match_report_type;

   logic clock = 1'b0;
   logic reset;

   wspm_req_if req ();
   wspm_rsp_if rsp ();

   wildcard_star_pattern_match_top dut (
      .clock   (clock),
      .reset   (reset),
      .req_in  (req),
      .rsp_out (rsp)
   );

   // matcher state as the testbench sees it
   logic [7:0]                     model_pattern [wspm_pkg::PATTERN_MAX];
   int                             model_len;
   logic [wspm_pkg::PATTERN_MAX:0] model_row;
   logic                           model_ovf;
   match_report_type               expected_reports [$];

   int error_count   = 0;
   int items_sent    = 0;
   int send_idle_pct = 0;
   int stall_pct     = 0;
   int quiet_cycles  = 0;

   // clock
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch: %s got %0d want %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // advance the local copy of the matcher by one accepted item
   function automatic void predict_match_step(input wspm_pkg::func_type f,
                                              input logic [7:0] s);
      logic [wspm_pkg::PATTERN_MAX:0] prev_row;
      logic [7:0]                     pc;
      logic [7:0]                     el;
      logic                           v;
      match_report_type               rep;
      case (f)
         wspm_pkg::FUNC_APPEND: begin
            if (model_len < wspm_pkg::PATTERN_MAX) begin
               model_pattern[model_len] = s;
               model_len++;
            end else begin
               model_ovf = 1'b1;
            end
         end
         wspm_pkg::FUNC_START: begin
            model_row    = '0;
            model_row[0] = 1'b1;
            for (int j = 1; j <= wspm_pkg::PATTERN_MAX; j++) begin
               v = 1'b0;
               if (j <= model_len && model_pattern[j-1] == wspm_pkg::SYM_STAR) begin
                  if (j == 1) v = model_row[0];
                  else v = model_row[j-1] | model_row[j-2];
               end
               model_row[j] = v;
            end
         end
         wspm_pkg::FUNC_TEXT: begin
            prev_row     = model_row;
            model_row[0] = 1'b0;
            for (int j = 1; j <= wspm_pkg::PATTERN_MAX; j++) begin
               v = 1'b0;
               if (j <= model_len) begin
                  pc = model_pattern[j-1];
                  if (pc == wspm_pkg::SYM_STAR) begin
                     // leading star has no element: only the column to its left
                     if (j >= 2) begin
                        el = model_pattern[j-2];
                        v = model_row[j-2] | model_row[j-1] |
                            (prev_row[j] & (el == s || el == wspm_pkg::SYM_ANY));
                     end else begin
                        v = model_row[0];
                     end
                  end else if (pc == wspm_pkg::SYM_ANY) begin
                     v = prev_row[j-1];
                  end else begin
                     v = prev_row[j-1] & (pc == s);
                  end
               end
               model_row[j] = v;
            end
         end
         default: begin
            rep.matched    = model_row[model_len] & ~model_ovf;
            rep.overflowed = model_ovf;
            expected_reports.push_back(rep);
            model_len    = 0;
            model_ovf    = 1'b0;
            model_row    = '0;
            model_row[0] = 1'b1;
         end
      endcase
   endfunction

   // drive one item at the falling edge, wait for the handshake
   task automatic send_item(input wspm_pkg::func_type f, input logic [7:0] s);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req.valid  <= 1'b0;
         req.func   <= wspm_pkg::func_type'(2'($urandom_range(3)));
         req.symbol <= 8'($urandom_range(255));
         @(negedge clock);
      end
      req.valid  <= 1'b1;
      req.func   <= f;
      req.symbol <= s;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      predict_match_step(f, s);
      items_sent++;
   endtask

   // result checker
   always @(posedge clock) begin
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_reports.size() == 0) begin
            report_mismatch("unexpected result, matched", rsp.matched, 0);
         end else begin
            if (rsp.matched !== expected_reports[0].matched)
               report_mismatch("matched", rsp.matched, expected_reports[0].matched);
            if (rsp.overflowed !== expected_reports[0].overflowed)
               report_mismatch("overflowed", rsp.overflowed, expected_reports[0].overflowed);
            void'(expected_reports.pop_front());
         end
      end
   end

   // receiver backpressure
   always @(negedge clock) begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
      end
   end

   // mostly small alphabet so stars and dots interact with the text
   function automatic logic [7:0] random_pattern_byte();
      int pick;
      pick = $urandom_range(9);
      case (pick)
         0, 1:    return CH_A;
         2, 3:    return CH_B;
         4, 5:    return wspm_pkg::SYM_STAR;
         6, 7:    return wspm_pkg::SYM_ANY;
         8:       return CH_C;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   function automatic logic [7:0] random_text_byte();
      int pick;
      pick = $urandom_range(7);
      case (pick)
         0, 1, 2: return CH_A;
         3, 4:    return CH_B;
         5:       return CH_C;
         6:       return wspm_pkg::SYM_STAR;
         default: return 8'($urandom_range(255));
      endcase
   endfunction

   // pattern, start (usually), text built to follow the pattern (sometimes corrupted or random), end
   task automatic send_sequence();
      logic [7:0] pat [$];
      logic [7:0] txt [$];
      logic [7:0] e;
      int         pick;
      int         plen;
      int         reps;
      pick = $urandom_range(99);
      if (pick < 80) plen = $urandom_range(6);
      else if (pick < 95) plen = $urandom_range(31, 7);
      else plen = $urandom_range(wspm_pkg::PATTERN_MAX + 2, wspm_pkg::PATTERN_MAX);
      repeat (plen) pat.push_back(random_pattern_byte());
      foreach (pat[i]) send_item(wspm_pkg::FUNC_APPEND, pat[i]);
      if ($urandom_range(7) != 0)
         send_item(wspm_pkg::FUNC_START, 8'($urandom_range(255)));
      if ($urandom_range(4) == 0) begin
         repeat ($urandom_range(8)) txt.push_back(random_text_byte());
      end else begin
         for (int i = 0; i < pat.size(); i++) begin
            e = pat[i];
            if (e != wspm_pkg::SYM_STAR) begin
               reps = (i + 1 < pat.size() && pat[i+1] == wspm_pkg::SYM_STAR) ?
                      $urandom_range(2) : 1;
               repeat (reps) txt.push_back(e == wspm_pkg::SYM_ANY ? random_text_byte() : e);
            end
         end
         if ($urandom_range(3) == 0) begin
            if (txt.size() > 0) txt[$urandom_range(txt.size() - 1)] = random_text_byte();
            else txt.push_back(random_text_byte());
         end
      end
      foreach (txt[i]) send_item(wspm_pkg::FUNC_TEXT, txt[i]);
      if ($urandom_range(9) == 0) send_item(wspm_pkg::FUNC_APPEND, random_pattern_byte());
      send_item(wspm_pkg::FUNC_END, 8'($urandom_range(255)));
   endtask

   task automatic test_empty_pattern();
      send_item(wspm_pkg::FUNC_END, 8'h00);
      send_item(wspm_pkg::FUNC_TEXT, 8'h00);
      send_item(wspm_pkg::FUNC_END, 8'hFF);
   endtask

   task automatic test_leading_star();
      send_item(wspm_pkg::FUNC_APPEND, wspm_pkg::SYM_STAR);
      send_item(wspm_pkg::FUNC_START, 8'h00);
      send_item(wspm_pkg::FUNC_END, 8'h00);
      send_item(wspm_pkg::FUNC_APPEND, wspm_pkg::SYM_STAR);
      send_item(wspm_pkg::FUNC_START, 8'hFF);
      send_item(wspm_pkg::FUNC_TEXT, CH_X);
      send_item(wspm_pkg::FUNC_END, 8'h00);
   endtask

   task automatic test_star_after_star();
      send_item(wspm_pkg::FUNC_APPEND, CH_A);
      send_item(wspm_pkg::FUNC_APPEND, wspm_pkg::SYM_STAR);
      send_item(wspm_pkg::FUNC_APPEND, wspm_pkg::SYM_STAR);
      send_item(wspm_pkg::FUNC_START, 8'h00);
      send_item(wspm_pkg::FUNC_TEXT, CH_A);
      send_item(wspm_pkg::FUNC_TEXT, wspm_pkg::SYM_STAR);
      send_item(wspm_pkg::FUNC_END, 8'h00);
   endtask

   task automatic test_byte_extremes();
      send_item(wspm_pkg::FUNC_APPEND, wspm_pkg::SYM_ANY);
      send_item(wspm_pkg::FUNC_APPEND, 8'hFF);
      send_item(wspm_pkg::FUNC_START, 8'h00);
      send_item(wspm_pkg::FUNC_TEXT, 8'h00);
      send_item(wspm_pkg::FUNC_TEXT, 8'hFF);
      send_item(wspm_pkg::FUNC_END, 8'hFF);
   endtask

   task automatic test_append_during_text();
      send_item(wspm_pkg::FUNC_APPEND, CH_A);
      send_item(wspm_pkg::FUNC_START, 8'h00);
      send_item(wspm_pkg::FUNC_TEXT, CH_A);
      send_item(wspm_pkg::FUNC_APPEND, wspm_pkg::SYM_STAR);
      send_item(wspm_pkg::FUNC_END, 8'h00);
   endtask

   // full pattern matched by full-length text, then a full pattern with one pattern byte too many
   task automatic test_pattern_full();
      repeat (wspm_pkg::PATTERN_MAX) send_item(wspm_pkg::FUNC_APPEND, wspm_pkg::SYM_ANY);
      send_item(wspm_pkg::FUNC_START, 8'h00);
      repeat (wspm_pkg::PATTERN_MAX)
         send_item(wspm_pkg::FUNC_TEXT, 8'($urandom_range(255)));
      send_item(wspm_pkg::FUNC_END, 8'h00);
      repeat (wspm_pkg::PATTERN_MAX) send_item(wspm_pkg::FUNC_APPEND, wspm_pkg::SYM_ANY);
      send_item(wspm_pkg::FUNC_START, 8'h00);
      repeat (wspm_pkg::PATTERN_MAX)
         send_item(wspm_pkg::FUNC_TEXT, 8'($urandom_range(255)));
      send_item(wspm_pkg::FUNC_APPEND, CH_A);
      send_item(wspm_pkg::FUNC_END, 8'h00);
   endtask

   // one random phase with the given idle and stall rates
   task automatic test_random_traffic(input int idle_pct, input int stall_rate, input int count);
      int target;
      send_idle_pct = idle_pct;
      stall_pct     = stall_rate;
      target        = items_sent + count;
      while (items_sent < target) begin
         if ($urandom_range(9) == 0)
            send_item(wspm_pkg::func_type'(2'($urandom_range(3))), 8'($urandom_range(255)));
         else
            send_sequence();
      end
   endtask

   initial begin
      model_len    = 0;
      model_ovf    = 1'b0;
      model_row    = '0;
      model_row[0] = 1'b1;
      reset        = 1'b1;
      req.valid    = 1'b0;
      req.func     = wspm_pkg::FUNC_APPEND;
      req.symbol   = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_empty_pattern();
      test_leading_star();
      test_star_after_star();
      test_byte_extremes();
      test_append_during_text();
      test_pattern_full();
      test_random_traffic(0, 0, 475);
      test_random_traffic(48, 0, 475);
      test_random_traffic(0, 48, 475);
      test_random_traffic(6, 6, 475);

      @(negedge clock);
      req.valid <= 1'b0;
      while (expected_reports.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (error_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
